@@ rtl/stack_slot_allocator_core_macros.svh @@
// Assertion helpers for the slot allocator.
`ifndef STACK_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define STACK_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ssa_pkg.sv @@
`default_nettype none

package ssa_pkg;

    localparam int ADDR_W = 48;
    localparam int IDX_W  = 6;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_TAKE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd2;

    // APB register index of base_address
    localparam logic REG_BASE_ADDRESS = 1'b0;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } find_result_t;

endpackage

`default_nettype wire

@@ rtl/stack_slot_allocator_core.sv @@
// Stack slot allocator core.
// Input stream s_axis carries commands: tdata[1:0] command (take, release, clear),
// tdata[49:2] release address. Output stream m_axis returns one result per
// command: tdata[47:0] slot address, [53:48] slot index, [55:54] status.
// base_address is written over APB at byte address 0 (64-bit data, low 48 used);
// write it only while no command is in flight.
// Each command is registered at the input, resolved against the slot bitmap in a
// single combinational pass (lowest-free priority encoder or address-to-index
// subtract and shift), and lands in the output register; one command is accepted
// every cycle while the receiver does not stall.
// The bitmap updates as a command moves into the output register, so the next
// command sees it with no bubble.
// If the receiver stalls, the result holds in the output register and one more
// command can wait in the input register; s_axis_tready drops only when both are
// full and m_axis_tready is low.
// Reset frees every slot, clears base_address and empties both registers.
`default_nettype none

`include "stack_slot_allocator_core_macros.svh"

module stack_slot_allocator_core #(
    parameter int SLOT_COUNT     = 64,
    parameter int SLOT_SIZE_LOG2 = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // command[1:0], release_address[49:2], zero pad

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // slot_address[47:0], slot_index[53:48],
                                             // status[55:54]

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int AW = ssa_pkg::ADDR_W;
    localparam int IW = ssa_pkg::IDX_W;

    logic [AW-1:0]                  base_address_reg;

    logic                           in_valid_reg;
    logic [ssa_pkg::CMD_W-1:0]      in_cmd_reg;
    logic [AW-1:0]                  in_rel_reg;

    logic                           out_valid_reg;
    logic [AW-1:0]                  out_addr_reg;
    logic [IW-1:0]                  out_idx_reg;
    logic [ssa_pkg::STAT_W-1:0]     out_status_reg;

    logic [SLOT_COUNT-1:0]          used_map_reg;
    logic [SLOT_COUNT-1:0]          used_map_next;

    logic                           s_accept;
    logic                           advance;
    logic                           cfg_write;

    logic [SLOT_COUNT-1:0]          grant;
    ssa_pkg::find_result_t          find;

    logic [AW-1:0]                  rel_diff;
    logic [AW-1:0]                  rel_idx_wide;
    logic                           rel_in_range;
    logic [SLOT_COUNT-1:0]          release_mask;

    logic [AW-1:0]                  res_addr;
    logic [IW-1:0]                  res_idx;
    logic [ssa_pkg::STAT_W-1:0]     res_status;

    // ---------------- handshake ----------------
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_status_reg, out_idx_reg, out_addr_reg};

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[0] == ssa_pkg::REG_BASE_ADDRESS) ?
                       {{(64-AW){1'b0}}, base_address_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (cfg_write && (paddr[0] == ssa_pkg::REG_BASE_ADDRESS))
        begin
            base_address_reg <= pwdata[AW-1:0];
        end
    end

    // ---------------- resolve ----------------
    ssa_free_finder #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_finder (
        .used_map (used_map_reg),
        .grant    (grant),
        .result   (find)
    );

    assign rel_diff     = base_address_reg - in_rel_reg;
    assign rel_idx_wide = rel_diff >> SLOT_SIZE_LOG2;
    assign rel_in_range = (in_rel_reg <= base_address_reg) &&
                          (rel_idx_wide < AW'(SLOT_COUNT));

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            release_mask[i] = (rel_idx_wide == AW'(i));
        end
    end

    always_comb
    begin
        used_map_next = used_map_reg;
        res_addr      = '0;
        res_idx       = '0;
        res_status    = ssa_pkg::ST_OK;
        case (in_cmd_reg)
            ssa_pkg::CMD_TAKE:
            begin
                if (find.found)
                begin
                    used_map_next = used_map_reg | grant;
                    res_addr      = base_address_reg - (AW'(find.index) << SLOT_SIZE_LOG2);
                    res_idx       = find.index;
                end
                else
                begin
                    res_status = ssa_pkg::ST_FULL;
                end
            end
            ssa_pkg::CMD_RELEASE:
            begin
                if (rel_in_range)
                begin
                    used_map_next = used_map_reg & ~release_mask;
                    res_idx       = rel_idx_wide[IW-1:0];
                end
                else
                begin
                    res_status = ssa_pkg::ST_BAD_ADDR;
                end
            end
            ssa_pkg::CMD_CLEAR:
            begin
                used_map_next = '0;
            end
            default:
            begin
                used_map_next = used_map_reg;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            used_map_reg  <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                used_map_reg  <= used_map_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg <= s_axis_tdata[1:0];
            in_rel_reg <= s_axis_tdata[49:2];
        end
        if (advance)
        begin
            out_addr_reg   <= res_addr;
            out_idx_reg    <= res_idx;
            out_status_reg <= res_status;
        end
    end

    // ---------------- assertions ----------------
    `SSA_ASSERT_NEXT(a_clear_empties_map, clk, rst_n,
        advance && (in_cmd_reg == ssa_pkg::CMD_CLEAR), used_map_reg == '0,
        "clear did not free every slot")
    `SSA_ASSERT_SAME(a_full_means_all_used, clk, rst_n,
        advance && (in_cmd_reg == ssa_pkg::CMD_TAKE) && !find.found, &used_map_reg,
        "full status with a free slot left")
    `SSA_ASSERT_NEXT(a_map_holds_when_idle, clk, rst_n,
        !advance, $stable(used_map_reg),
        "slot map changed without a command")
    `SSA_ASSERT_SAME(a_ready_low_only_when_full, clk, rst_n,
        !s_axis_tready, in_valid_reg && out_valid_reg && !m_axis_tready,
        "input stalled while a stage was free")

endmodule

`default_nettype wire

@@ rtl/ssa_free_finder.sv @@
`default_nettype none

// Lowest-free-slot priority encoder.
module ssa_free_finder #(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic [SLOT_COUNT-1:0] used_map,
    output logic [SLOT_COUNT-1:0]      grant,
    output ssa_pkg::find_result_t      result
);

    logic [SLOT_COUNT-1:0]      free_bits;
    logic [ssa_pkg::IDX_W-1:0]  index;

    assign free_bits = ~used_map;
    // isolate the lowest set bit
    assign grant = free_bits & (~free_bits + SLOT_COUNT'(1));

    always_comb
    begin
        index = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (grant[i])
            begin
                index = index | ssa_pkg::IDX_W'(i);
            end
        end
    end

    assign result.found = |free_bits;
    assign result.index = index;

endmodule

`default_nettype wire

@@ tb/stack_slot_allocator_core_tb.sv @@
`default_nettype none

module stack_slot_allocator_core_tb;

    localparam int SLOT_COUNT     = 64;
    localparam int SLOT_SIZE_LOG2 = 16;
    localparam logic [ssa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS  = 108;
    localparam int DRAIN_CYCLES = 4;

    // same bit order as m_axis_tdata: status on top, slot address at the bottom
    typedef struct packed {
        logic [ssa_pkg::STAT_W-1:0] status;
        logic [ssa_pkg::IDX_W-1:0]  index;
        logic [ssa_pkg::ADDR_W-1:0] address;
    } slot_result_t;

    class slot_scoreboard;
        logic [ssa_pkg::ADDR_W-1:0] base_address;
        logic [63:0]                used_map;
        slot_result_t               expected_q[$];
        int errors;
        int checked;
        int takes;
        int full_takes;
        int releases;
        int bad_releases;
        int clears;

        function new();
            base_address = '0;
            used_map     = '0;
            errors       = 0;
            checked      = 0;
            takes        = 0;
            full_takes   = 0;
            releases     = 0;
            bad_releases = 0;
            clears       = 0;
        endfunction

        // Predict the result of one accepted command and update the slot map.
        function void note_command(logic [ssa_pkg::CMD_W-1:0] cmd,
                                   logic [ssa_pkg::ADDR_W-1:0] rel);
            slot_result_t               r;
            logic [ssa_pkg::ADDR_W-1:0] offset;
            logic [ssa_pkg::ADDR_W-1:0] slot;
            bit                         found;
            int                         i;
            r     = '0;
            found = 1'b0;
            case (cmd)
                ssa_pkg::CMD_TAKE:
                begin
                    takes++;
                    for (i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (!found && !used_map[i])
                        begin
                            found       = 1'b1;
                            used_map[i] = 1'b1;
                            r.index     = ssa_pkg::IDX_W'(i);
                            r.address   = base_address -
                                          (ssa_pkg::ADDR_W'(i) << SLOT_SIZE_LOG2);
                        end
                    end
                    if (!found)
                    begin
                        r.status = ssa_pkg::ST_FULL;
                        full_takes++;
                    end
                end
                ssa_pkg::CMD_RELEASE:
                begin
                    releases++;
                    offset = base_address - rel;
                    slot   = offset >> SLOT_SIZE_LOG2;
                    if (rel > base_address || slot >= SLOT_COUNT)
                    begin
                        r.status = ssa_pkg::ST_BAD_ADDR;
                        bad_releases++;
                    end
                    else
                    begin
                        r.index        = ssa_pkg::IDX_W'(slot);
                        used_map[slot] = 1'b0;
                    end
                end
                ssa_pkg::CMD_CLEAR:
                begin
                    clears++;
                    used_map = '0;
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [55:0] data);
            slot_result_t got;
            slot_result_t want;
            got = data;
            checked++;
            if (expected_q.size() == 0)
            begin
                $error("result with no command outstanding: %h", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.address !== want.address)
            begin
                $error("slot_address mismatch: expected %h, got %h", want.address, got.address);
                errors++;
            end
            if (got.index !== want.index)
            begin
                $error("slot_index mismatch: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // command[1:0], release_address[49:2], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // slot_address[47:0], slot_index[53:48], status[55:54]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    slot_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int base_writes;

    stack_slot_allocator_core #(
        .SLOT_COUNT    (SLOT_COUNT),
        .SLOT_SIZE_LOG2(SLOT_SIZE_LOG2)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Outputs are stable from the falling edge up to the edge that takes the transaction.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    function automatic logic [ssa_pkg::ADDR_W-1:0] rand_address();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ssa_pkg::ADDR_W-1:0];
    endfunction

    // Mostly addresses inside the region (any offset within a slot), the rest
    // above the base, below the last slot, or anywhere.
    function automatic logic [ssa_pkg::ADDR_W-1:0] pick_release(
        logic [ssa_pkg::ADDR_W-1:0] base);
        int                         kind;
        logic [ssa_pkg::ADDR_W-1:0] r;
        kind = $urandom_range(0, 99);
        r    = rand_address();
        if (kind < 70)
            return base
                   - (ssa_pkg::ADDR_W'($urandom_range(0, SLOT_COUNT - 1)) << SLOT_SIZE_LOG2)
                   - ssa_pkg::ADDR_W'($urandom_range(0, (1 << SLOT_SIZE_LOG2) - 1));
        if (kind < 80)
            return base + 1 + (r >> $urandom_range(0, ssa_pkg::ADDR_W - 1));
        if (kind < 90)
            return base - (ssa_pkg::ADDR_W'(SLOT_COUNT) << SLOT_SIZE_LOG2)
                        - (r >> $urandom_range(0, ssa_pkg::ADDR_W - 1));
        return r;
    endfunction

    task automatic send_command(input logic [ssa_pkg::CMD_W-1:0] cmd,
                                input logic [ssa_pkg::ADDR_W-1:0] rel);
        bit ok;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, rel, cmd};
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end while (!ok);
        sb.note_command(cmd, rel);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write base_address, then read it back.
    task automatic write_base(input logic [ssa_pkg::ADDR_W-1:0] value);
        bit ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ssa_pkg::REG_BASE_ADDRESS;
        pwdata  <= 64'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end while (!ok);
        sb.base_address = value;
        base_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = pready;
            if (ok && prdata[ssa_pkg::ADDR_W-1:0] !== value)
            begin
                $error("base_address readback mismatch: expected %h, got %h",
                       value, prdata[ssa_pkg::ADDR_W-1:0]);
                sb.errors++;
            end
            @(posedge clk);
        end while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("** stack_slot_allocator_core: FAILED **");
        $finish;
    end

    initial
    begin
        int                         n;
        int                         p;
        int                         roll;
        logic [ssa_pkg::CMD_W-1:0]  cmd;
        logic [ssa_pkg::ADDR_W-1:0] base;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        base_writes   = 0;
        sb            = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base at zero: every slot past the first wraps to the top of the space
        write_base('0);
        send_command(ssa_pkg::CMD_TAKE, '0);
        send_command(ssa_pkg::CMD_TAKE, '1);
        send_command(ssa_pkg::CMD_RELEASE, 48'hFFFF_FFFF_0000);
        send_command(ssa_pkg::CMD_RELEASE, '1);
        send_command(ssa_pkg::CMD_RELEASE, '0);
        send_command(CMD_UNUSED, '1);
        send_command(ssa_pkg::CMD_CLEAR, '1);
        send_command(ssa_pkg::CMD_TAKE, '0);
        drain();

        // region of exactly SLOT_COUNT slots ending at address zero
        base = ssa_pkg::ADDR_W'(SLOT_COUNT) << SLOT_SIZE_LOG2;
        write_base(base);
        send_command(ssa_pkg::CMD_TAKE, '0);
        send_command(ssa_pkg::CMD_TAKE, '0);
        send_command(ssa_pkg::CMD_TAKE, '0);
        send_command(ssa_pkg::CMD_RELEASE, base - (48'd1 << SLOT_SIZE_LOG2) - 48'h1234);
        send_command(ssa_pkg::CMD_RELEASE, base - (48'd1 << SLOT_SIZE_LOG2) - 48'h1234);
        send_command(ssa_pkg::CMD_RELEASE, base + 1);
        send_command(ssa_pkg::CMD_RELEASE, '0);
        send_command(ssa_pkg::CMD_RELEASE, 48'hFFFF);
        send_command(ssa_pkg::CMD_TAKE, '1);
        send_command(ssa_pkg::CMD_CLEAR, '0);
        send_command(CMD_UNUSED, '0);

        for (p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    gap_pct = 0;  stall_pct = 0;  base = 48'h40_0000;
                end
                1:
                begin
                    gap_pct = 61; stall_pct = 0;  base = '1;
                end
                2:
                begin
                    gap_pct = 0;  stall_pct = 61; base = rand_address();
                end
                default:
                begin
                    gap_pct = 10; stall_pct = 10; base = 48'h2_0000;
                end
            endcase
            write_base(base);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                // a run of takes long enough to fill the map and overflow it
                if ((p == 1 && n == 0) || $urandom_range(0, 99) < 4)
                begin
                    repeat (SLOT_COUNT + 2) send_command(ssa_pkg::CMD_TAKE, rand_address());
                    n += SLOT_COUNT + 2;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 50)
                        cmd = ssa_pkg::CMD_TAKE;
                    else if (roll < 88)
                        cmd = ssa_pkg::CMD_RELEASE;
                    else if (roll < 93)
                        cmd = ssa_pkg::CMD_CLEAR;
                    else
                        cmd = CMD_UNUSED;
                    send_command(cmd, (cmd == ssa_pkg::CMD_RELEASE) ? pick_release(base)
                                                                    : rand_address());
                    n++;
                end
            end
        end
        drain();

        $display("Checked %0d results over 4 pacing modes and %0d base addresses:",
                 sb.checked, base_writes);
        $display("  takes %0d (map full %0d), releases %0d (out of region %0d), clears %0d",
                 sb.takes, sb.full_takes, sb.releases, sb.bad_releases, sb.clears);
        if (sb.errors == 0)
            $display("** stack_slot_allocator_core: PASSED **");
        else
            $display("** stack_slot_allocator_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
